// File: rtl/cpg_pkg.sv
package cpg_pkg;

  localparam int RADIUS_BITS = 11;
  localparam int OFS_W       = RADIUS_BITS + 1;
  localparam int CRD_W       = 16;
  localparam int DEC_W       = 16;
  localparam int COLOR_W     = 16;
  localparam int PEN_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 2;
  localparam int PT_IDX_W    = 3;

  localparam logic [PT_IDX_W-1:0] PT_LAST = 3'd7;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR    = 2'd2;

  localparam logic [CRD_W-1:0]   RST_SCREEN_WIDTH  = 16'd240;
  localparam logic [CRD_W-1:0]   RST_SCREEN_HEIGHT = 16'd320;
  localparam logic [COLOR_W-1:0] RST_FORE_COLOR    = 16'd0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic                start;
    logic                step;
    logic                load;
    logic [PT_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/circle_point_generator_unit.sv
// Midpoint circle point generator.
// Start transfer: loads the circle, produces no points.
// Next transfer with a circle running: eight points, one per cycle from the output
// register while the output side accepts them; the points are loaded in the EMIT state
// after the step, next input taken once the eighth point is loaded. A next with no circle is ignored.
// Reset (rst, synchronous): idle, no circle, screen 240 x 320, color 0.
module circle_point_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [cpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // center_x[15:0] center_y[31:16] radius[42:32] filled[43] pen_size[59:44]
  input  logic [cpg_pkg::IN_DATA_W-1:0]      s_tdata,
  // action[0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pixel_x[15:0] pixel_y[31:16] dot_size[47:32] dot_color[63:48]
  output logic [cpg_pkg::OUT_DATA_W-1:0]     m_tdata,
  // drawn[0] circle_end[1]
  output logic [cpg_pkg::OUT_USER_W-1:0]     m_tuser,
  output logic                               m_tlast
);

  cpg_pkg::cmd_t cmd;
  cpg_pkg::sts_t sts;

  logic [cpg_pkg::CRD_W-1:0]   pixel_x, pixel_y;
  logic [cpg_pkg::PEN_W-1:0]   dot_size;
  logic [cpg_pkg::COLOR_W-1:0] dot_color;
  logic                        drawn, circle_end;

  cpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_xfer   (s_tvalid && s_tready),
    .in_action (s_tuser),
    .sts       (sts),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  cpg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_center_x (s_tdata[15:0]),
    .in_center_y (s_tdata[31:16]),
    .in_radius   (s_tdata[42:32]),
    .in_filled   (s_tdata[43]),
    .in_pen_size (s_tdata[59:44]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .drawn       (drawn),
    .dot_size    (dot_size),
    .dot_color   (dot_color),
    .group_end   (m_tlast),
    .circle_end  (circle_end)
  );

  assign m_tdata = {dot_color, dot_size, pixel_y, pixel_x};
  assign m_tuser = {circle_end, drawn};

endmodule

// File: rtl/cpg_ctrl.sv
module cpg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_xfer,
  input  logic          in_action,
  input  cpg_pkg::sts_t sts,
  output logic          in_ready,
  output cpg_pkg::cmd_t cmd
);

  cpg_pkg::state_t state, state_next;
  logic [cpg_pkg::PT_IDX_W-1:0] idx, idx_next;

  assign in_ready = (state == cpg_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.load   = 1'b0;
    cmd.idx    = idx;
    case (state)
      cpg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == cpg_pkg::ACT_START) begin
            cmd.start = 1'b1;
          end else if (sts.busy) begin
            cmd.step   = 1'b1;
            idx_next   = '0;
            state_next = cpg_pkg::ST_EMIT;
          end
        end
      end
      cpg_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          idx_next = idx + 1'b1;
          if (idx == cpg_pkg::PT_LAST) begin
            state_next = cpg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = cpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpg_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// File: rtl/cpg_dp.sv
module cpg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  cpg_pkg::cmd_t                     cmd,
  output cpg_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [cpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [cpg_pkg::CRD_W-1:0]         in_center_x,
  input  logic [cpg_pkg::CRD_W-1:0]         in_center_y,
  input  logic [cpg_pkg::RADIUS_BITS-1:0]   in_radius,
  input  logic                              in_filled,
  input  logic [cpg_pkg::PEN_W-1:0]         in_pen_size,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpg_pkg::CRD_W-1:0]         pixel_x,
  output logic [cpg_pkg::CRD_W-1:0]         pixel_y,
  output logic                              drawn,
  output logic [cpg_pkg::PEN_W-1:0]         dot_size,
  output logic [cpg_pkg::COLOR_W-1:0]       dot_color,
  output logic                              group_end,
  output logic                              circle_end
);

  localparam int OW = cpg_pkg::OFS_W;
  localparam int CW = cpg_pkg::CRD_W;
  localparam int DW = cpg_pkg::DEC_W;

  logic [CW-1:0]                  screen_width;
  logic [CW-1:0]                  screen_height;
  logic [cpg_pkg::COLOR_W-1:0]    fore_color;

  logic                           busy;
  logic                           mode_filled;
  logic [CW-1:0]                  origin_x;
  logic [CW-1:0]                  origin_y;
  logic [OW-1:0]                  offset_minor;
  logic [OW-1:0]                  offset_major;
  logic [OW-1:0]                  span_index;
  logic [DW-1:0]                  decision;
  logic [cpg_pkg::PEN_W-1:0]      stored_pen;
  logic [OW-1:0]                  grp_a;
  logic [OW-1:0]                  grp_b;
  logic                           circle_fin;

  logic [OW-1:0] minor_next, major_next;
  logic [DW-1:0] decision_next;
  logic          fin_next;
  logic          span_step;

  // octant advance
  always_comb begin
    minor_next = offset_minor + 1'b1;
    major_next = offset_major;
    if (decision[DW-1]) begin
      decision_next = decision + (DW'(minor_next) << 2) + DW'(6);
    end else begin
      decision_next = decision + DW'(10) + (DW'(minor_next) << 2)
                      - (DW'(offset_major) << 2);
      if (offset_major != '0) begin
        major_next = offset_major - 1'b1;
      end
    end
    span_step = mode_filled && (span_index < offset_major);
    fin_next  = !span_step && (minor_next > major_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= cpg_pkg::RST_SCREEN_WIDTH;
      screen_height <= cpg_pkg::RST_SCREEN_HEIGHT;
      fore_color    <= cpg_pkg::RST_FORE_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        cpg_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        cpg_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        cpg_pkg::CFG_FORE_COLOR:    fore_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      mode_filled  <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
      offset_minor <= '0;
      offset_major <= '0;
      span_index   <= '0;
      decision     <= '0;
      stored_pen   <= '0;
      circle_fin   <= 1'b0;
    end else if (cmd.start) begin
      busy         <= 1'b1;
      mode_filled  <= in_filled;
      origin_x     <= in_center_x;
      origin_y     <= in_center_y;
      offset_minor <= '0;
      offset_major <= OW'(in_radius);
      span_index   <= '0;
      decision     <= DW'(3) - (DW'(in_radius) << 1);
      stored_pen   <= in_pen_size;
    end else if (cmd.step) begin
      circle_fin <= fin_next;
      busy       <= !fin_next;
      if (span_step) begin
        span_index <= span_index + 1'b1;
      end else begin
        offset_minor <= minor_next;
        offset_major <= major_next;
        decision     <= decision_next;
        span_index   <= minor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      grp_a <= offset_minor;
      grp_b <= mode_filled ? span_index : offset_major;
    end
  end

  // point selection
  logic [CW-1:0] ax, bx, pt_x, pt_y;

  always_comb begin
    ax = CW'(grp_a);
    bx = CW'(grp_b);
    case (cmd.idx)
      3'd0: begin pt_x = origin_x + ax; pt_y = origin_y + bx; end
      3'd1: begin pt_x = origin_x - ax; pt_y = origin_y + bx; end
      3'd2: begin pt_x = origin_x - bx; pt_y = origin_y + ax; end
      3'd3: begin pt_x = origin_x - bx; pt_y = origin_y - ax; end
      3'd4: begin pt_x = origin_x - ax; pt_y = origin_y - bx; end
      3'd5: begin pt_x = origin_x + ax; pt_y = origin_y - bx; end
      3'd6: begin pt_x = origin_x + bx; pt_y = origin_y - ax; end
      default: begin pt_x = origin_x + bx; pt_y = origin_y + ax; end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_x    <= pt_x;
      pixel_y    <= pt_y;
      drawn      <= (pt_x < screen_width) && (pt_y < screen_height);
      dot_size   <= stored_pen;
      dot_color  <= fore_color;
      group_end  <= (cmd.idx == cpg_pkg::PT_LAST);
      circle_end <= circle_fin;
    end
  end

  assign sts.busy     = busy;
  assign sts.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    busy |-> (offset_minor <= offset_major))
    else $error("minor offset passed major offset on a running circle");

  a_span_range: assert property (@(posedge clk) disable iff (rst)
    (busy && mode_filled) |-> (span_index >= offset_minor && span_index <= offset_major))
    else $error("span index out of range");

  a_fin_clears_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (busy == !circle_fin))
    else $error("busy and final-group flag disagree");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import cpg_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic                   action;
    logic [CRD_W-1:0]       cx;
    logic [CRD_W-1:0]       cy;
    logic [RADIUS_BITS-1:0] radius;
    logic                   fill;
    logic [PEN_W-1:0]       pen;
  } circle_req_t;

  typedef struct {
    logic [CRD_W-1:0]   px;
    logic [CRD_W-1:0]   py;
    logic               drawn;
    logic [PEN_W-1:0]   size;
    logic [COLOR_W-1:0] color;
    logic               grp_end;
    logic               circ_end;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  circle_req_t pending_items[$];
  point_t      expected_points[$];
  circle_req_t offer;

  int  send_idle = 35;
  int  recv_idle = 50;
  int  err_count = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  // predictor state
  logic [CRD_W-1:0]       scr_w = RST_SCREEN_WIDTH;
  logic [CRD_W-1:0]       scr_h = RST_SCREEN_HEIGHT;
  logic [COLOR_W-1:0]     fg_color = RST_FORE_COLOR;
  logic                   arc_busy = 1'b0;
  logic                   arc_filled = 1'b0;
  logic [CRD_W-1:0]       org_x = '0;
  logic [CRD_W-1:0]       org_y = '0;
  logic [OFS_W-1:0]       step_x = '0;
  logic [OFS_W-1:0]       step_y = '0;
  logic [OFS_W-1:0]       span_y = '0;
  logic signed [DEC_W-1:0] decis = '0;
  logic [PEN_W-1:0]       pen_q = '0;

  circle_point_generator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of point groups a full circle takes.
  function automatic int groups_for(int r, bit fl);
    int x, y, d, n;
    x = 0;
    y = r;
    d = 3 - 2 * r;
    n = 0;
    while (x <= y) begin
      n += fl ? (y - x + 1) : 1;
      x++;
      if (d < 0) begin
        d += 4 * x + 6;
      end else begin
        d += 10 + 4 * (x - y);
        if (y > 0) y--;
      end
    end
    return n;
  endfunction

  task automatic predict_points(input circle_req_t it);
    logic [CRD_W-1:0] a, b;
    logic [CRD_W-1:0] xs[8];
    logic [CRD_W-1:0] ys[8];
    logic fin;
    int d;
    point_t p;
    if (it.action == ACT_START) begin
      org_x = it.cx;
      org_y = it.cy;
      arc_filled = it.fill;
      pen_q = it.pen;
      step_x = '0;
      step_y = OFS_W'(it.radius);
      span_y = '0;
      d = 3 - 2 * int'(it.radius);
      decis = d[DEC_W-1:0];
      arc_busy = 1'b1;
      return;
    end
    if (!arc_busy) return;
    a = CRD_W'(step_x);
    b = arc_filled ? CRD_W'(span_y) : CRD_W'(step_y);
    xs[0] = org_x + a; ys[0] = org_y + b;
    xs[1] = org_x - a; ys[1] = org_y + b;
    xs[2] = org_x - b; ys[2] = org_y + a;
    xs[3] = org_x - b; ys[3] = org_y - a;
    xs[4] = org_x - a; ys[4] = org_y - b;
    xs[5] = org_x + a; ys[5] = org_y - b;
    xs[6] = org_x + b; ys[6] = org_y - a;
    xs[7] = org_x + b; ys[7] = org_y + a;
    fin = 1'b0;
    if (arc_filled && span_y < step_y) begin
      span_y++;
    end else begin
      step_x++;
      d = decis;
      if (d < 0) begin
        d += 4 * int'(step_x) + 6;
      end else begin
        d += 10 + 4 * (int'(step_x) - int'(step_y));
        if (step_y > 0) step_y--;
      end
      decis = d[DEC_W-1:0];
      span_y = step_x;
      if (step_x > step_y) begin
        arc_busy = 1'b0;
        fin = 1'b1;
      end
    end
    for (int k = 0; k < 8; k++) begin
      p.px = xs[k];
      p.py = ys[k];
      p.drawn = (xs[k] < scr_w) && (ys[k] < scr_h);
      p.size = pen_q;
      p.color = fg_color;
      p.grp_end = (k == 7);
      p.circ_end = fin;
      expected_points.push_back(p);
    end
  endtask

  // sender
  always @(posedge clk) begin : drive_proc
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_points(offer);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          offer = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= IN_DATA_W'({offer.pen, offer.fill, offer.radius, offer.cy, offer.cx});
          s_tuser <= offer.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endfunction

  // receiver and checker
  always @(posedge clk) begin : sink_proc
    point_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $error("point with no expectation: x=%0d y=%0d", m_tdata[15:0], m_tdata[31:16]);
          err_count++;
        end else begin
          want = expected_points.pop_front();
          check_field("pixel_x", want.px, m_tdata[15:0]);
          check_field("pixel_y", want.py, m_tdata[31:16]);
          check_field("drawn", want.drawn, m_tuser[0]);
          check_field("dot_size", want.size, m_tdata[47:32]);
          check_field("dot_color", want.color, m_tdata[63:48]);
          check_field("group_end", want.grp_end, m_tlast);
          check_field("circle_end", want.circ_end, m_tuser[1]);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic circle_req_t junk_next();
    circle_req_t q;
    q.action = ACT_NEXT;
    q.cx = CRD_W'($urandom);
    q.cy = CRD_W'($urandom);
    q.radius = RADIUS_BITS'($urandom);
    q.fill = 1'($urandom);
    q.pen = PEN_W'($urandom);
    return q;
  endfunction

  task automatic add_circle(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy,
                            input logic [RADIUS_BITS-1:0] r, input logic fl,
                            input logic [PEN_W-1:0] pen, input int nexts);
    circle_req_t q;
    q.action = ACT_START;
    q.cx = cx;
    q.cy = cy;
    q.radius = r;
    q.fill = fl;
    q.pen = pen;
    pending_items.push_back(q);
    repeat (nexts) pending_items.push_back(junk_next());
  endtask

  task automatic random_traffic(input int n);
    int made, sel, r, g;
    bit fl;
    logic [CRD_W-1:0] cx, cy;
    made = 0;
    while (made < n) begin
      sel = $urandom_range(99);
      fl = ($urandom_range(3) == 0);
      if ($urandom_range(1) == 0) begin
        cx = CRD_W'($urandom_range(511));
        cy = CRD_W'($urandom_range(511));
      end else begin
        cx = CRD_W'($urandom);
        cy = CRD_W'($urandom);
      end
      if (sel < 80) begin
        if (fl) r = $urandom_range(8);
        else if ($urandom_range(3) == 0) r = $urandom_range(80);
        else r = $urandom_range(20);
        g = groups_for(r, fl);
        if (g > 60) g = $urandom_range(20, 1);
        else if ($urandom_range(9) == 0) g = $urandom_range(g);
        add_circle(cx, cy, RADIUS_BITS'(r), fl, PEN_W'($urandom), g);
        made += 1 + g;
      end else if (sel < 92) begin
        g = $urandom_range(4);
        add_circle(cx, cy, RADIUS_BITS'($urandom_range(2047)), fl, PEN_W'($urandom), g);
        made += 1 + g;
      end else begin
        repeat ($urandom_range(3, 1)) pending_items.push_back(junk_next());
      end
    end
  endtask

  task automatic set_screen(input logic [CRD_W-1:0] w, input logic [CRD_W-1:0] h,
                            input logic [COLOR_W-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_index <= CFG_FORE_COLOR;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    fg_color = c;
    @(negedge clk);
  endtask

  // wait until every point is out, then let a start or ignored next finish
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset screen and color
    pending_items.push_back(junk_next());
    add_circle(16'd0, 16'd0, 11'd0, 1'b0, 16'd0, 2);
    add_circle(16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1, 16'hFFFF, 3);
    add_circle(16'd100, 16'd100, 11'd5, 1'b0, 16'd3, groups_for(5, 0));
    add_circle(16'd239, 16'd319, 11'd3, 1'b1, 16'h1234, groups_for(3, 1));
    add_circle(16'd5, 16'd5, 11'd1, 1'b1, 16'hAAAA, groups_for(1, 1));
    settle();

    set_screen(16'd0, 16'd0, 16'hFFFF);
    add_circle(16'd10, 16'd10, 11'd2, 1'b0, 16'd1, groups_for(2, 0));
    settle();

    // long output stall while a large circle is fed in
    set_screen(16'hFFFF, 16'hFFFF, COLOR_W'($urandom));
    hold_req = 1'b1;
    add_circle(16'h7FF0, 16'd100, 11'h7FF, 1'b0, 16'd7, 40);
    random_traffic(130);
    settle();

    send_idle = 50;
    recv_idle = 35;
    set_screen(CRD_W'($urandom_range(400, 1)), CRD_W'($urandom_range(400, 1)),
               COLOR_W'($urandom));
    random_traffic(130);
    settle();

    send_idle = 0;
    recv_idle = 0;
    set_screen(16'd1, 16'd1, COLOR_W'($urandom));
    random_traffic(50);
    settle();

    set_screen(CRD_W'($urandom_range(65535, 1)), CRD_W'($urandom_range(65535, 1)),
               COLOR_W'($urandom));
    random_traffic(80);
    settle();

    if (err_count == 0 && expected_points.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cpg_pkg.sv
rtl/cpg_ctrl.sv
rtl/cpg_dp.sv
rtl/circle_point_generator_unit.sv
tb/sv/testbench.sv
